FILE: hw/rtl/segment_digit_renderer_defines.svh
// Assertion macros shared by the segment digit renderer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SEGMENT_DIGIT_RENDERER_DEFINES_SVH
`define SEGMENT_DIGIT_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SDR_ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SDR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/sdr_pkg.sv
// Package for the segment digit renderer: display geometry, codes, state and
// controller/datapath bundle types, segment table and store address helper.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sdr_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH    = PAGE_COUNT * DISPLAY_WIDTH;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int COL_W          = $clog2(DISPLAY_WIDTH);
   localparam int ROW_W          = $clog2(DISPLAY_HEIGHT);
   localparam int PAGE_W         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int POS_W          = (COL_W > ROW_W) ? COL_W : ROW_W;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_MAX = 8'd9;
   localparam logic [3:0] DIGIT_ONE = 4'd1;

   localparam logic [7:0]        WIDTH_RESET  = 8'd5;
   localparam logic [6:0]        HEIGHT_RESET = 7'd7;
   localparam logic signed [7:0] GAP_RESET    = 8'sd2;

   typedef logic [6:0] seg_mask_type;

   localparam int SEG_TOP = 0;
   localparam int SEG_RU  = 1;
   localparam int SEG_RL  = 2;
   localparam int SEG_BOT = 3;
   localparam int SEG_LU  = 4;
   localparam int SEG_LL  = 5;
   localparam int SEG_MID = 6;

   localparam seg_mask_type M_TOP = seg_mask_type'(1 << SEG_TOP);
   localparam seg_mask_type M_RU  = seg_mask_type'(1 << SEG_RU);
   localparam seg_mask_type M_RL  = seg_mask_type'(1 << SEG_RL);
   localparam seg_mask_type M_BOT = seg_mask_type'(1 << SEG_BOT);
   localparam seg_mask_type M_LU  = seg_mask_type'(1 << SEG_LU);
   localparam seg_mask_type M_LL  = seg_mask_type'(1 << SEG_LL);
   localparam seg_mask_type M_MID = seg_mask_type'(1 << SEG_MID);

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_START = 2'd1,
      CMD_DRAW  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_DIGIT_WIDTH  = 2'd0,
      REG_DIGIT_HEIGHT = 2'd1,
      REG_DIGIT_GAP    = 2'd2
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_H_RD,
      ST_H_WR,
      ST_V_RD,
      ST_V_WR,
      ST_RD_ISSUE,
      ST_RD_WAIT
   } state_type;

   typedef struct packed {
      logic cursor_load;
      logic latch_req;
      logic setup;
      logic pass_start_v;
      logic vpass;
      logic pix_read;
      logic pix_write;
      logic advance;
      logic clear_step;
      logic rd_issue;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic draw_ok;
      logic h_needed;
      logic pix_en;
      logic last_sub;
      logic last_pos;
      logic rsp_busy;
   } dp_status_type;

   function automatic seg_mask_type seg_lookup(input logic [3:0] digit);
      seg_mask_type m;
      case (digit)
         4'd0:    m = M_TOP | M_LU | M_LL | M_RU | M_RL | M_BOT;
         4'd1:    m = M_RU | M_RL;
         4'd2:    m = M_TOP | M_RU | M_MID | M_LL | M_BOT;
         4'd3:    m = M_TOP | M_RU | M_RL | M_MID | M_BOT;
         4'd4:    m = M_LU | M_RU | M_RL | M_MID;
         4'd5:    m = M_TOP | M_LU | M_MID | M_RL | M_BOT;
         4'd6:    m = M_TOP | M_LU | M_LL | M_MID | M_RL | M_BOT;
         4'd7:    m = M_TOP | M_RU | M_RL;
         4'd8:    m = M_TOP | M_LU | M_LL | M_RU | M_RL | M_MID | M_BOT;
         4'd9:    m = M_TOP | M_LU | M_RU | M_RL | M_MID | M_BOT;
         default: m = '0;
      endcase
      return m;
   endfunction

   // Byte address of (page, column) in the page-organized store.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                    input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(page) * ADDR_W'(DISPLAY_WIDTH));
      return base + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sdr_req_if.sv
// Request channel interface of the segment digit renderer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sdr_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic signed [7:0] pos_x;
   logic signed [7:0] pos_y;
   logic [7:0]        char_code;
   logic [2:0]        read_page;
   logic [6:0]        read_column;

   modport source (
      output valid, cmd, pos_x, pos_y, char_code, read_page, read_column,
      input  ready
   );
   modport sink (
      input  valid, cmd, pos_x, pos_y, char_code, read_page, read_column,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/sdr_rsp_if.sv
// Response channel interface of the segment digit renderer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sdr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sdr_controller.sv
// Control state machine of the segment digit renderer.
// Depends on sdr_pkg; drives the datapath through dp_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module sdr_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [1:0]             req_cmd,
   output logic                        req_ready,
   output sdr_pkg::dp_cmd_type         dp_cmd,
   input  wire sdr_pkg::dp_status_type dp_status
);

   sdr_pkg::state_type state_ff;
   sdr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         sdr_pkg::ST_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (dp_status.clear_done) begin
               state_in = sdr_pkg::ST_IDLE;
            end
         end
         sdr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (sdr_pkg::cmd_type'(req_cmd))
                  sdr_pkg::CMD_CLEAR: begin
                     state_in = sdr_pkg::ST_CLEAR;
                  end
                  sdr_pkg::CMD_START: begin
                     dp_cmd.cursor_load = 1'b1;
                  end
                  sdr_pkg::CMD_DRAW: begin
                     dp_cmd.latch_req = 1'b1;
                     state_in         = sdr_pkg::ST_SETUP;
                  end
                  sdr_pkg::CMD_READ: begin
                     dp_cmd.latch_req = 1'b1;
                     state_in         = sdr_pkg::ST_RD_ISSUE;
                  end
                  default: begin
                     state_in = sdr_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         sdr_pkg::ST_SETUP: begin
            dp_cmd.setup = 1'b1;
            if (!dp_status.draw_ok) begin
               state_in = sdr_pkg::ST_IDLE;
            end else if (dp_status.h_needed) begin
               state_in = sdr_pkg::ST_H_RD;
            end else begin
               state_in = sdr_pkg::ST_V_RD;
            end
         end
         sdr_pkg::ST_H_RD: begin
            if (dp_status.pix_en) begin
               dp_cmd.pix_read = 1'b1;
               state_in        = sdr_pkg::ST_H_WR;
            end else if (dp_status.last_sub && dp_status.last_pos) begin
               dp_cmd.pass_start_v = 1'b1;
               state_in            = sdr_pkg::ST_V_RD;
            end else begin
               dp_cmd.advance = 1'b1;
            end
         end
         sdr_pkg::ST_H_WR: begin
            dp_cmd.pix_write = 1'b1;
            if (dp_status.last_sub && dp_status.last_pos) begin
               dp_cmd.pass_start_v = 1'b1;
               state_in            = sdr_pkg::ST_V_RD;
            end else begin
               dp_cmd.advance = 1'b1;
               state_in       = sdr_pkg::ST_H_RD;
            end
         end
         sdr_pkg::ST_V_RD: begin
            dp_cmd.vpass = 1'b1;
            if (dp_status.pix_en) begin
               dp_cmd.pix_read = 1'b1;
               state_in        = sdr_pkg::ST_V_WR;
            end else if (dp_status.last_sub && dp_status.last_pos) begin
               state_in = sdr_pkg::ST_IDLE;
            end else begin
               dp_cmd.advance = 1'b1;
            end
         end
         sdr_pkg::ST_V_WR: begin
            dp_cmd.vpass     = 1'b1;
            dp_cmd.pix_write = 1'b1;
            if (dp_status.last_sub && dp_status.last_pos) begin
               state_in = sdr_pkg::ST_IDLE;
            end else begin
               dp_cmd.advance = 1'b1;
               state_in       = sdr_pkg::ST_V_RD;
            end
         end
         sdr_pkg::ST_RD_ISSUE: begin
            dp_cmd.rd_issue = 1'b1;
            state_in        = sdr_pkg::ST_RD_WAIT;
         end
         sdr_pkg::ST_RD_WAIT: begin
            if (!dp_status.rsp_busy) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = sdr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sdr_datapath.sv
// Datapath of the segment digit renderer: settings, cursor, clipping bounds,
// pixel walk counters, single-port frame store and the response register.
// Depends on sdr_pkg; controlled by sdr_controller through dp_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module sdr_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_wdata,
   input  wire logic signed [7:0]   pos_x,
   input  wire logic signed [7:0]   pos_y,
   input  wire logic [7:0]          char_code,
   input  wire logic [2:0]          read_page,
   input  wire logic [6:0]          read_column,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               read_data,
   input  wire sdr_pkg::dp_cmd_type dp_cmd,
   output sdr_pkg::dp_status_type   dp_status
);

   localparam int X_W = 18;
   localparam int Y_W = 10;
   localparam int COL_W  = sdr_pkg::COL_W;
   localparam int ROW_W  = sdr_pkg::ROW_W;
   localparam int POS_W  = sdr_pkg::POS_W;
   localparam int ADDR_W = sdr_pkg::ADDR_W;
   localparam int PAGE_W = sdr_pkg::PAGE_W;

   localparam logic signed [X_W-1:0] DISP_W_S = X_W'(sdr_pkg::DISPLAY_WIDTH);
   localparam logic signed [Y_W-1:0] DISP_H_S = Y_W'(sdr_pkg::DISPLAY_HEIGHT);

   // Segment slots within one column (horizontal pass) or one row (vertical).
   localparam logic [1:0] SUB_TOP   = 2'd0;
   localparam logic [1:0] SUB_MID   = 2'd1;
   localparam logic [1:0] SUB_BOT   = 2'd2;
   localparam logic [1:0] SUB_LEFT  = 2'd0;
   localparam logic [1:0] SUB_RIGHT = 2'd1;

   logic [7:0]        width_ff;
   logic [6:0]        height_ff;
   logic signed [7:0] gap_ff;
   logic [15:0]       cursor_x_ff;
   logic signed [7:0] cursor_y_ff;
   logic [7:0]        char_ff;
   logic [2:0]        rd_page_ff;
   logic [6:0]        rd_col_ff;
   logic              rd_ok_ff;

   logic [COL_W-1:0]     col_left_ff;
   logic [COL_W-1:0]     col_hi_ff;
   logic [ROW_W-1:0]     row_lo_ff;
   logic [ROW_W-1:0]     row_hi_ff;
   logic signed [Y_W-1:0] mid_ff;
   logic                 mid_ok_ff;
   sdr_pkg::seg_mask_type attr_ff;

   logic [POS_W-1:0]  pos_ff;
   logic [1:0]        sub_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [7:0] store_mem [sdr_pkg::STORE_DEPTH];
   logic [7:0] mem_rdata_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   // Box geometry from the cursor and the settings.
   logic signed [X_W-1:0] x_s, w_s, x_end, x_last, mx;
   logic signed [Y_W-1:0] y_s, h_s, y_end, y_last, mid_in;
   logic                  box_x_ok, box_y_ok, mx_ok, mid_ok_in;
   logic [COL_W-1:0]      col_lo_in, col_hi_in, col_left_in;
   logic [ROW_W-1:0]      row_lo_in, row_hi_in;
   logic                  is_digit, is_one, draw_ok_in, h_needed_in;
   logic [3:0]            digit_idx;
   sdr_pkg::seg_mask_type attr_in;

   always_comb begin
      x_s    = signed'({{(X_W-16){cursor_x_ff[15]}}, cursor_x_ff});
      w_s    = signed'(X_W'(width_ff));
      x_end  = x_s + w_s;
      x_last = x_end - signed'(X_W'(1));
      mx     = x_s + signed'(X_W'(width_ff >> 1));

      y_s    = signed'({{(Y_W-8){cursor_y_ff[7]}}, cursor_y_ff});
      h_s    = signed'(Y_W'(height_ff));
      y_end  = y_s + h_s;
      y_last = y_end - signed'(Y_W'(1));
      mid_in = y_s + signed'(Y_W'(height_ff >> 1));

      box_x_ok  = !x_end[X_W-1] && (x_end != '0) && (x_s < DISP_W_S);
      box_y_ok  = !y_end[Y_W-1] && (y_end != '0) && (y_s < DISP_H_S);
      mx_ok     = !mx[X_W-1] && (mx < DISP_W_S);
      mid_ok_in = !mid_in[Y_W-1] && (mid_in < DISP_H_S);

      col_lo_in = x_s[X_W-1] ? '0 : x_s[COL_W-1:0];
      col_hi_in = (x_end > DISP_W_S) ? COL_W'(sdr_pkg::DISPLAY_WIDTH - 1)
                                     : x_last[COL_W-1:0];
      row_lo_in = y_s[Y_W-1] ? '0 : y_s[ROW_W-1:0];
      row_hi_in = (y_end > DISP_H_S) ? ROW_W'(sdr_pkg::DISPLAY_HEIGHT - 1)
                                     : y_last[ROW_W-1:0];

      is_digit  = (char_ff >= sdr_pkg::CHAR_ZERO) &&
                  (char_ff <= sdr_pkg::CHAR_ZERO + sdr_pkg::DIGIT_MAX);
      digit_idx = 4'(char_ff - sdr_pkg::CHAR_ZERO);
      is_one    = (digit_idx == sdr_pkg::DIGIT_ONE);

      // The one is a single centered column drawn over every visible row.
      attr_in     = is_one ? (sdr_pkg::M_LU | sdr_pkg::M_LL)
                           : sdr_pkg::seg_lookup(digit_idx);
      col_left_in = is_one ? mx[COL_W-1:0] : col_lo_in;
      h_needed_in = |(attr_in & (sdr_pkg::M_TOP | sdr_pkg::M_MID | sdr_pkg::M_BOT));
      draw_ok_in  = is_digit && (width_ff != '0) && (height_ff != '0) &&
                    box_x_ok && box_y_ok && (!is_one || mx_ok);
   end

   // Current pixel of the walk.
   logic [ROW_W-1:0]  h_row, v_row, pix_row;
   logic [COL_W-1:0]  v_col, pix_col;
   logic              h_en, v_en, upper, pix_en, last_sub, last_pos;
   logic [ADDR_W-1:0] pix_addr, rd_addr, mem_addr;
   logic [7:0]        mem_wdata;
   logic              mem_we, mem_re;
   logic              clear_done;

   always_comb begin
      case (sub_ff)
         SUB_TOP: begin
            h_row = row_lo_ff;
            h_en  = attr_ff[sdr_pkg::SEG_TOP];
         end
         SUB_MID: begin
            h_row = mid_ff[ROW_W-1:0];
            h_en  = attr_ff[sdr_pkg::SEG_MID] && mid_ok_ff;
         end
         SUB_BOT: begin
            h_row = row_hi_ff;
            h_en  = attr_ff[sdr_pkg::SEG_BOT];
         end
         default: begin
            h_row = row_hi_ff;
            h_en  = 1'b0;
         end
      endcase

      v_row = pos_ff[ROW_W-1:0];
      upper = signed'(Y_W'(v_row)) < mid_ff;
      case (sub_ff)
         SUB_LEFT: begin
            v_col = col_left_ff;
            v_en  = upper ? attr_ff[sdr_pkg::SEG_LU] : attr_ff[sdr_pkg::SEG_LL];
         end
         SUB_RIGHT: begin
            v_col = col_hi_ff;
            v_en  = upper ? attr_ff[sdr_pkg::SEG_RU] : attr_ff[sdr_pkg::SEG_RL];
         end
         default: begin
            v_col = col_hi_ff;
            v_en  = 1'b0;
         end
      endcase

      pix_row  = dp_cmd.vpass ? v_row : h_row;
      pix_col  = dp_cmd.vpass ? v_col : pos_ff[COL_W-1:0];
      pix_en   = dp_cmd.vpass ? v_en : h_en;
      last_sub = dp_cmd.vpass ? (sub_ff == SUB_RIGHT) : (sub_ff == SUB_BOT);
      last_pos = dp_cmd.vpass ? (pos_ff == POS_W'(row_hi_ff))
                              : (pos_ff == POS_W'(col_hi_ff));

      pix_addr = sdr_pkg::store_addr(PAGE_W'(pix_row >> 3), pix_col);
      rd_addr  = sdr_pkg::store_addr(PAGE_W'(rd_page_ff), COL_W'(rd_col_ff));
      if (dp_cmd.clear_step) begin
         mem_addr = clr_addr_ff;
      end else if (dp_cmd.rd_issue) begin
         mem_addr = rd_addr;
      end else begin
         mem_addr = pix_addr;
      end
      mem_we     = dp_cmd.clear_step || dp_cmd.pix_write;
      mem_re     = dp_cmd.pix_read || dp_cmd.rd_issue;
      mem_wdata  = dp_cmd.clear_step ? '0 : (mem_rdata_ff | (8'(1) << pix_row[2:0]));
      clear_done = (clr_addr_ff == ADDR_W'(sdr_pkg::STORE_DEPTH - 1));
   end

   always_comb begin
      dp_status.clear_done = clear_done;
      dp_status.draw_ok    = draw_ok_in;
      dp_status.h_needed   = h_needed_in;
      dp_status.pix_en     = pix_en;
      dp_status.last_sub   = last_sub;
      dp_status.last_pos   = last_pos;
      dp_status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // Settings and cursor.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= sdr_pkg::WIDTH_RESET;
         height_ff   <= sdr_pkg::HEIGHT_RESET;
         gap_ff      <= sdr_pkg::GAP_RESET;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         if (csr_we) begin
            case (sdr_pkg::csr_reg_type'(csr_index))
               sdr_pkg::REG_DIGIT_WIDTH:  width_ff  <= csr_wdata;
               sdr_pkg::REG_DIGIT_HEIGHT: height_ff <= csr_wdata[6:0];
               sdr_pkg::REG_DIGIT_GAP:    gap_ff    <= signed'(csr_wdata);
               default: begin
               end
            endcase
         end
         if (dp_cmd.cursor_load) begin
            cursor_x_ff <= 16'(pos_x);
            cursor_y_ff <= pos_y;
         end else if (dp_cmd.setup) begin
            // The cursor advances whether or not anything is drawn.
            cursor_x_ff <= cursor_x_ff + 16'(width_ff) + 16'(gap_ff);
         end
      end
   end

   // Transaction payload and draw bounds.
   always_ff @(posedge clock) begin
      if (dp_cmd.latch_req) begin
         char_ff    <= char_code;
         rd_page_ff <= read_page;
         rd_col_ff  <= read_column;
         rd_ok_ff   <= (32'(read_page) < sdr_pkg::PAGE_COUNT) &&
                       (32'(read_column) < sdr_pkg::DISPLAY_WIDTH);
      end
      if (dp_cmd.setup) begin
         col_left_ff <= col_left_in;
         col_hi_ff   <= col_hi_in;
         row_lo_ff   <= row_lo_in;
         row_hi_ff   <= row_hi_in;
         mid_ff      <= mid_in;
         mid_ok_ff   <= mid_ok_in;
         attr_ff     <= attr_in;
      end
   end

   // Walk counters and clear sweep address.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sub_ff      <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (dp_cmd.setup) begin
            pos_ff <= h_needed_in ? POS_W'(col_lo_in) : POS_W'(row_lo_in);
            sub_ff <= '0;
         end else if (dp_cmd.pass_start_v) begin
            pos_ff <= POS_W'(row_lo_ff);
            sub_ff <= '0;
         end else if (dp_cmd.advance) begin
            if (last_sub) begin
               sub_ff <= '0;
               pos_ff <= pos_ff + POS_W'(1);
            end else begin
               sub_ff <= sub_ff + 2'd1;
            end
         end
         if (dp_cmd.clear_step) begin
            clr_addr_ff <= clear_done ? '0 : clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   // Frame store: one port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_addr];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (dp_cmd.rsp_load) begin
         rsp_data_ff <= mem_rdata_ff & {8{rd_ok_ff}};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign read_data = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/segment_digit_renderer.sv
// Top level of the segment digit renderer: controller plus datapath.
// Depends on sdr_pkg, sdr_req_if, sdr_rsp_if, sdr_controller, sdr_datapath
// and the assertion macros in segment_digit_renderer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_digit_renderer_defines.svh"

// The block keeps a 128 by 64 monochrome frame store organized in pages of
// eight rows per byte and draws seven-segment digits into it. A request
// transaction carries one of four commands: clear the store, start a string at
// a pixel position, draw one character at the cursor, or read one store byte.
// Only a read returns a response transaction; the other commands return none.
// Digits are ORed into the store clipped to the screen, other characters draw
// nothing, and every draw command moves the cursor by width plus gap.
// The store lives in a single-port memory, so each pixel is a read and then
// a write of its byte. One command is worked on at a time. A clear sweeps all
// 1024 bytes, one per cycle, and the same sweep runs after reset before the
// first request is taken. Start string only loads the cursor. Draw sets up the
// box, walks three segment slots per visible column when a top, middle or
// bottom segment is lit, then two slots per visible row; a slot with its
// segment off writes nothing, one that sets a pixel reads and writes its byte.
// A read passes the issue and wait states and loads the response register
// once it is free; a new request is accepted while an earlier response still
// waits. Settings must be written through the csr port only while no command
// is in flight; the block itself does not enforce this.
module segment_digit_renderer (
   input  wire logic       clock,
   input  wire logic       reset,
   sdr_req_if.sink         req_chan,
   sdr_rsp_if.source       rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   // Commands from the controller and status back from the datapath.
   sdr_pkg::dp_cmd_type    dp_cmd;
   sdr_pkg::dp_status_type dp_status;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [7:0]             read_data;

   sdr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   sdr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pos_x       (req_chan.pos_x),
      .pos_y       (req_chan.pos_y),
      .char_code   (req_chan.char_code),
      .read_page   (req_chan.read_page),
      .read_column (req_chan.read_column),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .read_data   (read_data),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.read_data = read_data;

   // While a request can be taken, nothing may be writing the store.
   `SDR_ASSERT_IMPLIES(a_idle_no_store_write, clock, reset, req_ready, !(dp_cmd.pix_write || dp_cmd.clear_step), "store written while accepting requests")

   // A pixel write always completes the read issued the cycle before.
   `SDR_ASSERT_NEXT(a_write_after_read, clock, reset, dp_cmd.pix_read, dp_cmd.pix_write, "pixel read not followed by its write")

   // The response register is only loaded when it is free or being drained.
   `SDR_ASSERT_IMPLIES(a_rsp_load_free, clock, reset, dp_cmd.rsp_load, !rsp_valid || rsp_chan.ready, "response overwritten before it was taken")

   // Right after reset the clear sweep runs and no request is accepted.
   `SDR_ASSERT_IMPLIES(a_clear_after_reset, clock, reset, $fell(reset), !req_ready, "request accepted before the store was cleared")

endmodule

`default_nettype wire

FILE: verif/tb_segment_digit_renderer.sv
// Self-checking testbench for segment_digit_renderer: directed and random command
// transactions, with every read byte compared against an in-bench frame store model.
// Depends on sdr_pkg, sdr_req_if, sdr_rsp_if and the segment_digit_renderer RTL.
`timescale 1ns / 1ps

module tb_segment_digit_renderer;

   // The slowest single commands are a full-screen box and a store clear. A
   // quiet wait of SETTLE_CYCLES outlasts either and guarantees the block is
   // idle before the settings change or the run ends.
   localparam int SETTLE_CYCLES = 1500;
   localparam int IDLE_MAX      = 16;

   // One request transaction as the testbench builds it. Every field is always
   // driven; the ones the command does not use carry random noise.
   typedef struct {
      sdr_pkg::cmd_type  cmd;
      logic signed [7:0] pos_x;
      logic signed [7:0] pos_y;
      logic [7:0]        char_code;
      logic [2:0]        read_page;
      logic [6:0]        read_column;
   } render_cmd_type;

   // Lit segments for each decimal digit. Digit one has its own drawing rule,
   // so its entry is never consulted.
   localparam sdr_pkg::seg_mask_type GLYPH_SEGMENTS [0:9] = '{
      sdr_pkg::M_TOP | sdr_pkg::M_LU | sdr_pkg::M_LL | sdr_pkg::M_RU | sdr_pkg::M_RL |
         sdr_pkg::M_BOT,
      sdr_pkg::M_RU | sdr_pkg::M_RL,
      sdr_pkg::M_TOP | sdr_pkg::M_RU | sdr_pkg::M_MID | sdr_pkg::M_LL | sdr_pkg::M_BOT,
      sdr_pkg::M_TOP | sdr_pkg::M_RU | sdr_pkg::M_RL | sdr_pkg::M_MID | sdr_pkg::M_BOT,
      sdr_pkg::M_LU | sdr_pkg::M_RU | sdr_pkg::M_RL | sdr_pkg::M_MID,
      sdr_pkg::M_TOP | sdr_pkg::M_LU | sdr_pkg::M_MID | sdr_pkg::M_RL | sdr_pkg::M_BOT,
      sdr_pkg::M_TOP | sdr_pkg::M_LU | sdr_pkg::M_LL | sdr_pkg::M_MID | sdr_pkg::M_RL |
         sdr_pkg::M_BOT,
      sdr_pkg::M_TOP | sdr_pkg::M_RU | sdr_pkg::M_RL,
      sdr_pkg::M_TOP | sdr_pkg::M_LU | sdr_pkg::M_LL | sdr_pkg::M_RU | sdr_pkg::M_RL |
         sdr_pkg::M_MID | sdr_pkg::M_BOT,
      sdr_pkg::M_TOP | sdr_pkg::M_LU | sdr_pkg::M_RU | sdr_pkg::M_RL | sdr_pkg::M_MID |
         sdr_pkg::M_BOT
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   sdr_req_if req_if();
   sdr_rsp_if rsp_if();

   segment_digit_renderer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model state: a copy of the frame store, the cursor and the digit box
   // settings. It is updated at the clock edge where each request transaction
   // is accepted, so it always reflects the order the block sees.
   logic [7:0] store_img [sdr_pkg::STORE_DEPTH];
   logic [15:0] cursor_col;
   logic [7:0]  cursor_row;
   logic [7:0]  box_width;
   logic [6:0]  box_height;
   logic [7:0]  box_gap;

   // Bytes that outstanding read transactions must return, oldest first.
   logic [7:0] pending_bytes [$];

   int sent_count = 0;
   int mismatches = 0;
   // While set, neither side inserts idle cycles, giving back-to-back stretches.
   bit steady_flow = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest legal run.
   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int idle_cycles();
      return steady_flow ? 0 : int'($urandom_range(0, IDLE_MAX));
   endfunction

   function automatic int clip(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [7:0] glyph_code(input int digit);
      return sdr_pkg::CHAR_ZERO + 8'(digit);
   endfunction

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      do c = 8'($urandom);
      while (c >= sdr_pkg::CHAR_ZERO && c <= sdr_pkg::CHAR_ZERO + sdr_pkg::DIGIT_MAX);
      return c;
   endfunction

   // Set one pixel; anything off the screen is silently dropped.
   function automatic void plot(input int px, input int py);
      if (px < 0 || px >= sdr_pkg::DISPLAY_WIDTH || py < 0 || py >= sdr_pkg::DISPLAY_HEIGHT)
         return;
      store_img[(py / 8) * sdr_pkg::DISPLAY_WIDTH + px][py % 8] = 1'b1;
   endfunction

   // OR one character into the store at the cursor. The box is clipped to the
   // screen first: the top and bottom segments land on the first and last
   // visible rows and the side columns on the first and last visible columns,
   // while the middle row stays at half the height and is simply lost when it
   // falls off the screen.
   function automatic void render_glyph(input logic [7:0] code);
      int x, y, w, h, xs, xe, ys, ye, half, dx, dy;
      sdr_pkg::seg_mask_type segs;
      bit upper;
      x = int'($signed(cursor_col));
      y = int'($signed(cursor_row));
      w = int'(box_width);
      h = int'(box_height);
      if (code < sdr_pkg::CHAR_ZERO || code > sdr_pkg::CHAR_ZERO + sdr_pkg::DIGIT_MAX)
         return;
      if (w == 0 || h == 0)
         return;
      if (x + w <= 0 || x >= sdr_pkg::DISPLAY_WIDTH || y + h <= 0 ||
          y >= sdr_pkg::DISPLAY_HEIGHT)
         return;
      xs = (x < 0) ? -x : 0;
      xe = (x + w > sdr_pkg::DISPLAY_WIDTH) ? sdr_pkg::DISPLAY_WIDTH - x : w;
      ys = (y < 0) ? -y : 0;
      ye = (y + h > sdr_pkg::DISPLAY_HEIGHT) ? sdr_pkg::DISPLAY_HEIGHT - y : h;
      half = h / 2;
      // Digit one is a single column through the middle of the box.
      if (code - sdr_pkg::CHAR_ZERO == sdr_pkg::DIGIT_ONE) begin
         for (dy = ys; dy < ye; dy++)
            plot(x + w / 2, y + dy);
         return;
      end
      segs = GLYPH_SEGMENTS[code - sdr_pkg::CHAR_ZERO];
      for (dx = xs; dx < xe; dx++) begin
         if (segs[sdr_pkg::SEG_TOP]) plot(x + dx, y + ys);
         if (segs[sdr_pkg::SEG_MID]) plot(x + dx, y + half);
         if (segs[sdr_pkg::SEG_BOT]) plot(x + dx, y + ye - 1);
      end
      for (dy = ys; dy < ye; dy++) begin
         upper = (dy < half);
         if (upper ? segs[sdr_pkg::SEG_LU] : segs[sdr_pkg::SEG_LL]) plot(x + xs, y + dy);
         if (upper ? segs[sdr_pkg::SEG_RU] : segs[sdr_pkg::SEG_RL]) plot(x + xe - 1, y + dy);
      end
   endfunction

   function automatic void apply_render_cmd(input render_cmd_type r);
      case (r.cmd)
         sdr_pkg::CMD_CLEAR: begin
            // The cursor survives a clear.
            foreach (store_img[i]) store_img[i] = '0;
         end
         sdr_pkg::CMD_START: begin
            cursor_col = 16'(int'(r.pos_x));
            cursor_row = r.pos_y;
         end
         sdr_pkg::CMD_DRAW: begin
            render_glyph(r.char_code);
            // Every character advances, drawn or not; the cursor wraps at 16 bits.
            cursor_col = cursor_col + 16'(int'(box_width) + int'($signed(box_gap)));
         end
         sdr_pkg::CMD_READ: begin
            pending_bytes.push_back(
               store_img[int'(r.read_page) * sdr_pkg::DISPLAY_WIDTH + int'(r.read_column)]);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic render_cmd_type noise_fields();
      render_cmd_type r;
      r.cmd         = sdr_pkg::cmd_type'($urandom_range(0, 3));
      r.pos_x       = 8'($urandom);
      r.pos_y       = 8'($urandom);
      r.char_code   = 8'($urandom);
      r.read_page   = 3'($urandom);
      r.read_column = 7'($urandom);
      return r;
   endfunction

   // Send one request transaction. Inputs move only on the falling edge; the
   // handshake is sampled on the rising edge, where the model is updated too.
   // A zero idle count keeps valid high straight into the next transaction.
   task automatic issue(input render_cmd_type r);
      int idle;
      idle = idle_cycles();
      repeat (idle) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.cmd         <= r.cmd;
      req_if.pos_x       <= r.pos_x;
      req_if.pos_y       <= r.pos_y;
      req_if.char_code   <= r.char_code;
      req_if.read_page   <= r.read_page;
      req_if.read_column <= r.read_column;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      apply_render_cmd(r);
      sent_count++;
   endtask

   task automatic clear_store();
      render_cmd_type r;
      r = noise_fields();
      r.cmd = sdr_pkg::CMD_CLEAR;
      issue(r);
   endtask

   task automatic start_at(input int x, input int y);
      render_cmd_type r;
      r = noise_fields();
      r.cmd   = sdr_pkg::CMD_START;
      r.pos_x = 8'(x);
      r.pos_y = 8'(y);
      issue(r);
   endtask

   task automatic draw_char(input logic [7:0] code);
      render_cmd_type r;
      r = noise_fields();
      r.cmd       = sdr_pkg::CMD_DRAW;
      r.char_code = code;
      issue(r);
   endtask

   task automatic read_byte(input int page, input int col);
      render_cmd_type r;
      r = noise_fields();
      r.cmd         = sdr_pkg::CMD_READ;
      r.read_page   = 3'(page);
      r.read_column = 7'(col);
      issue(r);
   endtask

   // Drop valid and hold off until every outstanding read has come back.
   task automatic await_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Commands without a response may still be running once the reads are
   // all back, so wait out the longest command before touching settings.
   task automatic settle();
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on consecutive cycles while the block is idle.
   // Bit 7 of the height write is random; the register only keeps seven bits.
   task automatic program_digit_box(input int w, input int h, input int g);
      settle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sdr_pkg::REG_DIGIT_WIDTH;
      csr_wdata <= 8'(w);
      @(negedge clock);
      csr_index <= sdr_pkg::REG_DIGIT_HEIGHT;
      csr_wdata <= {1'($urandom), 7'(h)};
      @(negedge clock);
      csr_index <= sdr_pkg::REG_DIGIT_GAP;
      csr_wdata <= 8'(g);
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= 8'($urandom);
      box_width  = 8'(w);
      box_height = 7'(h);
      box_gap    = 8'(g);
   endtask

   // Reset settings are still in force here: 5 by 7 boxes with a gap of 2.
   // The boxes are placed so they hang off each edge of the screen.
   task automatic test_clipped_boxes();
      clear_store();
      read_byte(0, 0);
      // Hanging off the top-left corner; the middle row lands on row 0.
      start_at(-2, -3);
      draw_char(glyph_code(8));
      read_byte(0, 0);
      read_byte(0, 1);
      read_byte(0, 2);
      // Digit one with its center column left of the screen draws nothing.
      // The three that follows has its middle row above the screen.
      start_at(-3, -5);
      draw_char(glyph_code(1));
      draw_char(glyph_code(3));
      read_byte(0, 4);
      read_byte(0, 6);
      read_byte(0, 8);
      // A letter draws nothing but still moves the cursor along.
      draw_char(8'h41);
      draw_char(glyph_code(7));
      read_byte(0, 11);
      read_byte(0, 18);
      read_byte(0, 22);
      // Hanging off the bottom-right corner.
      start_at(124, 60);
      draw_char(glyph_code(8));
      read_byte(7, 124);
      read_byte(7, 127);
      // Wholly off the screen.
      start_at(-128, -128);
      draw_char(glyph_code(0));
      read_byte(0, 0);
   endtask

   // Zero width or zero height boxes draw nothing; the store keeps what the
   // corner test left behind. A zero width with the most negative gap also
   // walks the cursor far to the left.
   task automatic test_zero_size_box();
      program_digit_box(0, 9, -128);
      start_at(1, 0);
      draw_char(glyph_code(8));
      draw_char(glyph_code(8));
      read_byte(0, 1);
      read_byte(0, 2);
      program_digit_box(6, 0, 5);
      start_at(0, 0);
      draw_char(glyph_code(0));
      draw_char(glyph_code(1));
      read_byte(0, 0);
      read_byte(0, 8);
   endtask

   // With a step of 255 + 127 = 382 pixels, 172 characters move the cursor by
   // 65704, which wraps the 16-bit cursor all the way round: starting at -100
   // it ends up at column 68, through the signed boundary on the way. The
   // final digit is then drawn there, clipped at the right and bottom edges.
   task automatic test_cursor_wrap();
      program_digit_box(255, 127, 127);
      start_at(-100, 10);
      repeat (172) draw_char(non_digit());
      draw_char(glyph_code(8));
      read_byte(1, 67);
      read_byte(1, 68);
      read_byte(1, 100);
      read_byte(1, 127);
      read_byte(4, 68);
      read_byte(7, 127);
   endtask

   // A well-formed string most of the time: place the cursor near the screen,
   // draw a few characters, then read bytes that the boxes should touch.
   // Now and then a clear, a random transaction of any kind, a far-off start
   // or a stray read is mixed in, and sometimes the sender drains all reads.
   task automatic random_sequence();
      int w, step, x0, y0, ndraw, nread, k, col, row, roll;
      w    = int'(box_width);
      step = w + int'($signed(box_gap));
      steady_flow = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 19);
      if (roll == 0)
         clear_store();
      else if (roll <= 2)
         issue(noise_fields());
      if ($urandom_range(0, 3) == 0) begin
         x0 = int'($signed(8'($urandom)));
         y0 = int'($signed(8'($urandom)));
      end else begin
         x0 = clip(int'($urandom_range(0, 150)) - 20, -128, 127);
         y0 = int'($urandom_range(0, 72)) - 8;
      end
      start_at(x0, y0);
      ndraw = $urandom_range(1, 5);
      repeat (ndraw) begin
         if ($urandom_range(0, 9) == 0)
            draw_char(non_digit());
         else
            draw_char(glyph_code($urandom_range(0, 9)));
      end
      nread = $urandom_range(1, 4);
      repeat (nread) begin
         if ($urandom_range(0, 4) == 0) begin
            read_byte($urandom_range(0, 7), $urandom_range(0, 127));
         end else begin
            k   = $urandom_range(0, ndraw - 1);
            col = clip(x0 + k * step + int'($urandom_range(0, w + 3)) - 2, 0, 127);
            row = clip(y0 + int'($urandom_range(0, int'(box_height))), 0, 63);
            read_byte(row / 8, col);
         end
      end
      if ($urandom_range(0, 9) == 0)
         await_results();
   endtask

   task automatic run_random_phase(input int w, input int h, input int g, input int items);
      int goal;
      program_digit_box(w, h, g);
      goal = sent_count + items;
      while (sent_count < goal)
         random_sequence();
      steady_flow = 1'b0;
   endtask

   // Response side: draw a stall, then hold ready high until a response
   // transaction is taken, and check it against the oldest pending read.
   initial begin : response_sink
      int stall;
      logic [7:0] want;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = idle_cycles();
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         if (pending_bytes.size() == 0) begin
            $error("read_data: response with no read outstanding, expected none, actual %02h",
                   rsp_if.read_data);
            mismatches++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_if.read_data !== want) begin
               $error("read_data: expected %02h, actual %02h", want, rsp_if.read_data);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = sdr_pkg::REG_DIGIT_WIDTH;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.cmd         = sdr_pkg::CMD_CLEAR;
      req_if.pos_x       = '0;
      req_if.pos_y       = '0;
      req_if.char_code   = '0;
      req_if.read_page   = '0;
      req_if.read_column = '0;
      foreach (store_img[i]) store_img[i] = '0;
      cursor_col = '0;
      cursor_row = '0;
      box_width  = sdr_pkg::WIDTH_RESET;
      box_height = sdr_pkg::HEIGHT_RESET;
      box_gap    = sdr_pkg::GAP_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its store after reset before it takes a request;
      // the first send simply waits on ready through that sweep.
      test_clipped_boxes();
      test_zero_size_box();
      test_cursor_wrap();

      // Extremes first, then the widest settings with only a few items since
      // each full-screen box is a long walk over the whole store, then several
      // random small boxes and finally the reset settings again.
      run_random_phase(1, 1, -128, 40);
      run_random_phase(128, 64, 127, 12);
      run_random_phase(128, 64, -128, 8);
      run_random_phase(255, 127, -1, 8);
      repeat (4)
         run_random_phase($urandom_range(1, 16), $urandom_range(1, 24),
                          int'($urandom_range(0, 16)) - 8, 50);
      run_random_phase(sdr_pkg::WIDTH_RESET, sdr_pkg::HEIGHT_RESET, sdr_pkg::GAP_RESET, 80);

      // Let any late or stray response show up before the verdict.
      settle();
      if (mismatches == 0 && pending_bytes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
